FILE: sv/lcs_pkg.sv
// Package for the link connect supervisor: types, codes and register defaults.
package lcs_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_W-1:0] CONNECT_BUDGET_RESET = 32'd30000;
  localparam logic [CFG_W-1:0] REJOIN_INTERVAL_RESET = 32'd4000;
  localparam logic [CFG_W-1:0] RETRY_BACKOFF_RESET = 32'd3000;
  localparam logic [CFG_W-1:0] LINK_GRACE_RESET = 32'd3000;

  typedef enum logic [1:0] {
    MODE_OFF        = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_CONNECTED  = 2'd2,
    MODE_BACKOFF    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    LINK_UP      = 2'd0,
    LINK_BADAUTH = 2'd1,
    LINK_NONET   = 2'd2,
    LINK_OTHER   = 2'd3
  } link_t;

  typedef enum logic [2:0] {
    ST_OFF         = 3'd0,
    ST_CONNECTING  = 3'd1,
    ST_CONNECTED   = 3'd2,
    ST_AUTH_FAILED = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_RETRYING    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONNECT_BUDGET  = 3'd0,
    REG_REJOIN_INTERVAL = 3'd1,
    REG_RETRY_BACKOFF   = 3'd2,
    REG_LINK_GRACE      = 3'd3,
    REG_HAS_PASSWORD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] connect_budget_ms;
    logic [CFG_W-1:0] rejoin_interval_ms;
    logic [CFG_W-1:0] retry_backoff_ms;
    logic [CFG_W-1:0] link_grace_ms;
    logic             has_password;
  } cfg_t;

  // One poll's decisions.
  typedef struct packed {
    logic join_req;
    logic leave;
    logic pso;
  } action_t;

  typedef struct packed {
    logic    power_save_off;
    logic    leave_request;
    logic    join_secured;
    logic    join_request;
    status_t status_code;
    mode_t   mode;
  } result_t;

endpackage

FILE: sv/lcs_step.sv
// One poll of the supervisor: next state and result from the current state.
module lcs_step
  import lcs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  mode_t                mode,
  input  logic [TIME_BITS-1:0] entered_at,
  input  logic [TIME_BITS-1:0] last_join_at,
  input  logic [TIME_BITS-1:0] lost_at,
  input  logic                 lost_valid,
  input  link_t                last_link,
  input  cfg_t                 cfg,
  input  logic                 enable,
  input  logic [TIME_BITS-1:0] now,
  input  link_t                link_status,
  output mode_t                mode_next,
  output logic [TIME_BITS-1:0] entered_at_next,
  output logic [TIME_BITS-1:0] last_join_at_next,
  output logic [TIME_BITS-1:0] lost_at_next,
  output logic                 lost_valid_next,
  output link_t                last_link_next,
  output result_t              result
);

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [TIME_BITS-1:0] since, since_join, since_lost;
  logic [CMP_W-1:0] since_w, since_join_w, since_lost_w;
  logic [CMP_W-1:0] budget_w, rejoin_w, backoff_w, grace_w;
  action_t act;

  // Differences wrap at the time width.
  assign since = now - entered_at;
  assign since_join = now - last_join_at;
  assign since_lost = now - lost_at;
  assign since_w = CMP_W'(since);
  assign since_join_w = CMP_W'(since_join);
  assign since_lost_w = CMP_W'(since_lost);
  assign budget_w = CMP_W'(cfg.connect_budget_ms);
  assign rejoin_w = CMP_W'(cfg.rejoin_interval_ms);
  assign backoff_w = CMP_W'(cfg.retry_backoff_ms);
  assign grace_w = CMP_W'(cfg.link_grace_ms);

  // Next state
  always_comb begin
    mode_next = mode;
    entered_at_next = entered_at;
    last_join_at_next = last_join_at;
    lost_at_next = lost_at;
    lost_valid_next = lost_valid;
    last_link_next = last_link;
    act = '0;
    if (!enable && mode != MODE_OFF) begin
      act.leave = 1'b1;
      mode_next = MODE_OFF;
      entered_at_next = now;
    end else if (enable && mode == MODE_OFF) begin
      act.join_req = 1'b1;
      last_join_at_next = now;
      mode_next = MODE_CONNECTING;
      entered_at_next = now;
    end else begin
      case (mode)
        MODE_CONNECTING: begin
          last_link_next = link_status;
          if (link_status == LINK_UP) begin
            lost_valid_next = 1'b0;
            act.pso = 1'b1;
            mode_next = MODE_CONNECTED;
            entered_at_next = now;
          end else if (link_status == LINK_BADAUTH || since_w > budget_w) begin
            act.leave = 1'b1;
            mode_next = MODE_BACKOFF;
            entered_at_next = now;
          end else if (since_join_w >= rejoin_w) begin
            act.join_req = 1'b1;
            last_join_at_next = now;
          end
        end
        MODE_CONNECTED: begin
          last_link_next = link_status;
          if (link_status == LINK_UP) begin
            lost_valid_next = 1'b0;
          end else if (!lost_valid) begin
            lost_at_next = now;
            lost_valid_next = 1'b1;
          end else if (since_lost_w >= grace_w) begin
            act.leave = 1'b1;
            lost_valid_next = 1'b0;
            mode_next = MODE_BACKOFF;
            entered_at_next = now;
          end
        end
        MODE_BACKOFF: begin
          if (since_w >= backoff_w) begin
            act.join_req = 1'b1;
            last_join_at_next = now;
            mode_next = MODE_CONNECTING;
            entered_at_next = now;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    result.mode = mode_next;
    result.join_request = act.join_req;
    result.join_secured = act.join_req & cfg.has_password;
    result.leave_request = act.leave;
    result.power_save_off = act.pso;
    case (mode_next)
      MODE_OFF:        result.status_code = ST_OFF;
      MODE_CONNECTING: result.status_code = ST_CONNECTING;
      MODE_CONNECTED:  result.status_code = ST_CONNECTED;
      MODE_BACKOFF: begin
        case (last_link_next)
          LINK_BADAUTH: result.status_code = ST_AUTH_FAILED;
          LINK_NONET:   result.status_code = ST_NOT_FOUND;
          default:      result.status_code = ST_RETRYING;
        endcase
      end
      default:         result.status_code = ST_OFF;
    endcase
  end

endmodule

FILE: sv/link_connect_supervisor_core.sv
// An accepted poll waits in the input register and moves on to the result
// register when the output is free (m_tvalid low or m_tready high).
// Throughput: one poll per cycle unless m_tready stalls the output; the state update
// sits between the input and result registers, so each poll sees the state of the one before.
// Reset (rst, synchronous): state off, times zero, last link other down,
// registers at defaults, both pipeline stages empty.
module link_connect_supervisor_core
  import lcs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [0] enable, [32:1] time_now_ms, [34:33] link_status, [39:35] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] mode, [4:2] status_code, [5] join_request, [6] join_secured,
  // [7] leave_request, [8] power_save_off, [15:9] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  cfg_t cfg;

  logic                 in_valid;
  logic                 in_enable;
  logic [CFG_W-1:0]     in_time;
  link_t                in_link;
  logic                 advance;

  mode_t                mode;
  logic [TIME_BITS-1:0] entered_at, last_join_at, lost_at;
  logic                 lost_valid;
  link_t                last_link;

  mode_t                mode_next;
  logic [TIME_BITS-1:0] entered_at_next, last_join_at_next, lost_at_next;
  logic                 lost_valid_next;
  link_t                last_link_next;
  result_t              result_next;
  result_t              result;

  logic [CMP_W-1:0]     now_w;
  logic [TIME_BITS-1:0] now;

  assign advance = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  assign now_w = CMP_W'(in_time);
  assign now = now_w[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connect_budget_ms <= CONNECT_BUDGET_RESET;
      cfg.rejoin_interval_ms <= REJOIN_INTERVAL_RESET;
      cfg.retry_backoff_ms <= RETRY_BACKOFF_RESET;
      cfg.link_grace_ms <= LINK_GRACE_RESET;
      cfg.has_password <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONNECT_BUDGET:  cfg.connect_budget_ms <= cfg_data;
        REG_REJOIN_INTERVAL: cfg.rejoin_interval_ms <= cfg_data;
        REG_RETRY_BACKOFF:   cfg.retry_backoff_ms <= cfg_data;
        REG_LINK_GRACE:      cfg.link_grace_ms <= cfg_data;
        REG_HAS_PASSWORD:    cfg.has_password <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_enable <= s_tdata[0];
      in_time <= s_tdata[32:1];
      in_link <= link_t'(s_tdata[34:33]);
    end
  end

  lcs_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .mode              (mode),
    .entered_at        (entered_at),
    .last_join_at      (last_join_at),
    .lost_at           (lost_at),
    .lost_valid        (lost_valid),
    .last_link         (last_link),
    .cfg               (cfg),
    .enable            (in_enable),
    .now               (now),
    .link_status       (in_link),
    .mode_next         (mode_next),
    .entered_at_next   (entered_at_next),
    .last_join_at_next (last_join_at_next),
    .lost_at_next      (lost_at_next),
    .lost_valid_next   (lost_valid_next),
    .last_link_next    (last_link_next),
    .result            (result_next)
  );

  // Supervisor state moves only when the poll goes on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OFF;
      entered_at <= '0;
      last_join_at <= '0;
      lost_at <= '0;
      lost_valid <= 1'b0;
      last_link <= LINK_OTHER;
    end else if (in_valid && advance) begin
      mode <= mode_next;
      entered_at <= entered_at_next;
      last_join_at <= last_join_at_next;
      lost_at <= lost_at_next;
      lost_valid <= lost_valid_next;
      last_link <= last_link_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      result <= result_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'(result);

  a_join_connecting: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.join_request |-> result.mode == MODE_CONNECTING)
    else $error("join issued outside connecting");

  a_pso_connected: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.power_save_off |-> result.mode == MODE_CONNECTED
      && !result.join_request && !result.leave_request)
    else $error("power save off without entering connected");

  a_leave_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.leave_request |->
      (result.mode == MODE_OFF || result.mode == MODE_BACKOFF))
    else $error("leave while staying on link");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && advance) |=> $stable(mode) && $stable(entered_at))
    else $error("state moved without a poll");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for link_connect_supervisor_core: stream driver, monitor, poll predictor.
`timescale 1ns / 100ps
module tb_top;
  import lcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL = 120;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    bit          enable;
    logic [31:0] now;
    link_t       link;
  } poll_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [0] enable, [32:1] time_now_ms, [34:33] link_status, [39:35] zero
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [1:0] mode, [4:2] status_code, [5] join_request, [6] join_secured,
  // [7] leave_request, [8] power_save_off, [15:9] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  link_connect_supervisor_core #(.TIME_BITS(32)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor copy of the supervisor state and its registers
  cfg_t        shadow_cfg;
  mode_t       sup_mode;
  logic [31:0] sup_entered;
  logic [31:0] sup_last_join;
  logic [31:0] sup_lost_at;
  bit          sup_lost_valid;
  link_t       sup_last_link;

  poll_t       poll_q[$];
  result_t     expected_results[$];
  poll_t       cur_poll;

  bit          in_taken, out_taken;
  int unsigned in_gap, out_gap, in_stretch, out_stretch, stall_left;
  bit          in_calm, out_calm, stall_done;
  int unsigned polls_accepted, results_seen, mismatches, idle_cycles;
  int unsigned join_count, leave_count, pso_count;

  logic [31:0] gen_now;
  bit          gen_enable;
  link_t       gen_link;

  task automatic predict_supervisor_poll(input poll_t p);
    result_t     r;
    logic [31:0] since, since_join, since_lost;
    bit          jn, lv, ps, moved;
    mode_t       nxt;
    jn = 0;
    lv = 0;
    ps = 0;
    moved = 0;
    nxt = sup_mode;
    since = p.now - sup_entered;
    since_join = p.now - sup_last_join;
    since_lost = p.now - sup_lost_at;
    if (!p.enable && sup_mode != MODE_OFF) begin
      lv = 1;
      nxt = MODE_OFF;
      moved = 1;
    end else if (p.enable && sup_mode == MODE_OFF) begin
      // link status is not looked at on the enabling poll
      jn = 1;
      nxt = MODE_CONNECTING;
      moved = 1;
    end else begin
      case (sup_mode)
        MODE_CONNECTING: begin
          sup_last_link = p.link;
          if (p.link == LINK_UP) begin
            sup_lost_valid = 0;
            ps = 1;
            nxt = MODE_CONNECTED;
            moved = 1;
          end else if (p.link == LINK_BADAUTH || since > shadow_cfg.connect_budget_ms) begin
            lv = 1;
            nxt = MODE_BACKOFF;
            moved = 1;
          end else if (since_join >= shadow_cfg.rejoin_interval_ms) begin
            jn = 1;
          end
        end
        MODE_CONNECTED: begin
          sup_last_link = p.link;
          if (p.link == LINK_UP) begin
            sup_lost_valid = 0;
          end else if (!sup_lost_valid) begin
            sup_lost_at = p.now;
            sup_lost_valid = 1;
          end else if (since_lost >= shadow_cfg.link_grace_ms) begin
            lv = 1;
            sup_lost_valid = 0;
            nxt = MODE_BACKOFF;
            moved = 1;
          end
        end
        MODE_BACKOFF: begin
          if (since >= shadow_cfg.retry_backoff_ms) begin
            jn = 1;
            nxt = MODE_CONNECTING;
            moved = 1;
          end
        end
        default: ;
      endcase
    end
    if (moved) begin
      sup_mode = nxt;
      sup_entered = p.now;
    end
    if (jn) sup_last_join = p.now;

    r = '0;
    r.mode = sup_mode;
    case (sup_mode)
      MODE_OFF:        r.status_code = ST_OFF;
      MODE_CONNECTING: r.status_code = ST_CONNECTING;
      MODE_CONNECTED:  r.status_code = ST_CONNECTED;
      default: begin
        case (sup_last_link)
          LINK_BADAUTH: r.status_code = ST_AUTH_FAILED;
          LINK_NONET:   r.status_code = ST_NOT_FOUND;
          default:      r.status_code = ST_RETRYING;
        endcase
      end
    endcase
    r.join_request = jn;
    r.join_secured = jn & shadow_cfg.has_password;
    r.leave_request = lv;
    r.power_save_off = ps;
    expected_results.push_back(r);
  endtask

  // Per-item idle draw; each stretch is either calm (no idling, one in four) or has random gaps
  function automatic int unsigned draw_gap(inout int unsigned left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Input side: item accepted at posedge, next one staged at negedge
  always @(negedge clk) begin : poll_driver
    bit nv;
    if (rst) begin
      nv = 0;
    end else begin
      nv = s_tvalid;
      if (in_taken) begin
        in_taken = 0;
        nv = 0;
        in_gap = draw_gap(in_stretch, in_calm);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (poll_q.size() > 0) begin
          cur_poll = poll_q.pop_front();
          s_tdata <= {5'b0, cur_poll.link, cur_poll.now, cur_poll.enable};
          nv = 1;
        end
      end
    end
    s_tvalid <= nv;
  end

  // Output side, including one long hold-off while polls are still queued
  always @(negedge clk) begin : result_sink
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 0;
        out_gap = draw_gap(out_stretch, out_calm);
      end
      if (!stall_done && results_seen >= 300 && poll_q.size() > 20) begin
        stall_left = LONG_STALL;
        stall_done = 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : poll_monitor
    result_t got, want;
    bit      moved_any;
    if (!rst) begin
      moved_any = 0;
      if (s_tvalid && s_tready) begin
        predict_supervisor_poll(cur_poll);
        in_taken = 1;
        polls_accepted++;
        moved_any = 1;
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[8:0]);
        out_taken = 1;
        results_seen++;
        moved_any = 1;
        join_count += (got.join_request === 1'b1);
        leave_count += (got.leave_request === 1'b1);
        pso_count += (got.power_save_off === 1'b1);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d with nothing expected: tdata=%h", results_seen, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.mode !== want.mode || got.status_code !== want.status_code ||
              got.join_request !== want.join_request ||
              got.join_secured !== want.join_secured ||
              got.leave_request !== want.leave_request ||
              got.power_save_off !== want.power_save_off) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result %0d: expected mode=%0d st=%0d join=%b sec=%b leave=%b pso=%b,",
                        " got mode=%0d st=%0d join=%b sec=%b leave=%b pso=%b"},
                       results_seen, want.mode, want.status_code, want.join_request,
                       want.join_secured, want.leave_request, want.power_save_off,
                       got.mode, got.status_code, got.join_request, got.join_secured,
                       got.leave_request, got.power_save_off);
          end
        end
      end
      idle_cycles = moved_any ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results still due",
                 idle_cycles, expected_results.size());
        $display("link_connect_supervisor_core: mismatch");
        $finish;
      end
    end
  end

  task automatic add_poll(input bit en, input logic [31:0] t, input link_t l);
    poll_t p;
    p.enable = en;
    p.now = t;
    p.link = l;
    poll_q.push_back(p);
  endtask

  // Sticky enable and link level so that connects and grace windows play out
  task automatic queue_polls(input int count, input int unsigned step_max);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) gen_now = $urandom;
      else if (pick >= 8) gen_now += $urandom_range(0, step_max);
      if (gen_enable) begin
        if ($urandom_range(0, 24) == 0) gen_enable = 0;
      end else if ($urandom_range(0, 2) == 0) begin
        gen_enable = 1;
      end
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 9);
        gen_link = pick < 4 ? LINK_UP : pick == 4 ? LINK_BADAUTH :
                   pick < 7 ? LINK_NONET : LINK_OTHER;
      end
      add_poll(gen_enable, gen_now, gen_link);
    end
  endtask

  // Checked at posedge, where the driver's queue and s_tvalid are settled
  task automatic wait_drained();
    do @(posedge clk);
    while (poll_q.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Caller lowers cfg_we after the last write of a batch
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CONNECT_BUDGET:  shadow_cfg.connect_budget_ms = val;
      REG_REJOIN_INTERVAL: shadow_cfg.rejoin_interval_ms = val;
      REG_RETRY_BACKOFF:   shadow_cfg.retry_backoff_ms = val;
      REG_LINK_GRACE:      shadow_cfg.link_grace_ms = val;
      REG_HAS_PASSWORD:    shadow_cfg.has_password = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] budget, input logic [31:0] rejoin,
                           input logic [31:0] backoff, input logic [31:0] grace,
                           input logic [31:0] pw, input int count,
                           input int unsigned step_max);
    wait_drained();
    write_reg(REG_CONNECT_BUDGET, budget);
    write_reg(REG_REJOIN_INTERVAL, rejoin);
    write_reg(REG_RETRY_BACKOFF, backoff);
    write_reg(REG_LINK_GRACE, grace);
    write_reg(REG_HAS_PASSWORD, pw);
    cfg_we <= 1'b0;
    queue_polls(count, step_max);
  endtask

  initial begin
    shadow_cfg = '{CONNECT_BUDGET_RESET, REJOIN_INTERVAL_RESET, RETRY_BACKOFF_RESET,
                   LINK_GRACE_RESET, 1'b0};
    sup_mode = MODE_OFF;
    sup_entered = '0;
    sup_last_join = '0;
    sup_lost_at = '0;
    sup_lost_valid = 0;
    sup_last_link = LINK_OTHER;
    gen_enable = 1;
    gen_link = LINK_OTHER;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk at reset register values
    add_poll(0, 32'd0, LINK_UP);          // disabled and off
    add_poll(1, 32'd100, LINK_UP);        // enable: join, link ignored
    add_poll(1, 32'd200, LINK_OTHER);
    add_poll(1, 32'd4100, LINK_NONET);    // rejoin exactly on interval
    add_poll(1, 32'd30100, LINK_OTHER);   // budget reached but not exceeded
    add_poll(1, 32'd30101, LINK_NONET);   // budget exceeded
    add_poll(1, 32'd30200, LINK_UP);      // backoff ignores link
    add_poll(1, 32'd33101, LINK_BADAUTH); // backoff over, reconnect
    add_poll(1, 32'd33102, LINK_UP);      // connected, power save off
    add_poll(1, 32'd34000, LINK_OTHER);   // loss recorded
    add_poll(1, 32'd36999, LINK_OTHER);
    add_poll(1, 32'd37000, LINK_UP);      // link back inside grace
    add_poll(1, 32'd37001, LINK_NONET);
    add_poll(1, 32'd40001, LINK_OTHER);   // grace used up
    add_poll(0, 32'd40002, LINK_UP);      // disable while active
    add_poll(0, 32'd40003, LINK_BADAUTH);
    add_poll(1, 32'd40004, LINK_BADAUTH);
    add_poll(1, 32'd40005, LINK_BADAUTH); // bad auth abort
    add_poll(1, 32'd43005, LINK_UP);
    add_poll(0, 32'd43006, LINK_NONET);   // disable from connecting
    add_poll(1, 32'hFFFF_FFF0, LINK_OTHER);
    add_poll(1, 32'h0000_0010, LINK_OTHER); // time wraps
    add_poll(1, 32'hFFFF_FFFF, LINK_UP);  // link up: connected, power save off
    add_poll(0, 32'd0, LINK_OTHER);       // disable from connected

    gen_now = 32'hFFFF_FF00;
    run_phase(32'd60, 32'd12, 32'd25, 32'd18, 32'd1, 140, 15);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 140, 3);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 140, 1000);
    run_phase(CONNECT_BUDGET_RESET, REJOIN_INTERVAL_RESET, RETRY_BACKOFF_RESET,
              LINK_GRACE_RESET, 32'd0, 140, 2500);
    run_phase($urandom_range(0, 120), $urandom_range(0, 40), $urandom_range(0, 60),
              $urandom_range(0, 60), $urandom_range(0, 1), 140, 40);
    wait_drained();
    repeat (4) @(posedge clk);

    $display({"summary: %0d polls checked under reset, tight, all-zero, all-ones,",
              " default and random registers"}, polls_accepted);
    $display({"summary: %0d joins, %0d leaves, %0d power-save-off pulses,",
              " one %0d-cycle output hold-off"},
             join_count, leave_count, pso_count, LONG_STALL);
    if (mismatches == 0) begin
      $display("link_connect_supervisor_core: match");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("link_connect_supervisor_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lcs_pkg.sv
sv/lcs_step.sv
sv/link_connect_supervisor_core.sv
test/tb_top.sv
